// File: src/nir_pkg.sv
// nir_pkg: shared types and constants for the nec infrared frame receiver
// no dependencies; imported by every module of the block

package nir_pkg;

  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned EDGE_W     = 7;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam logic [EDGE_W-1:0] FRAME_EDGES = 7'd67;

  localparam logic [INTERVAL_W-1:0] MARK_MIN_US       = 16'd400;
  localparam logic [INTERVAL_W-1:0] MARK_MAX_US       = 16'd700;
  localparam logic [INTERVAL_W-1:0] ONE_SPACE_MIN_US  = 16'd1500;
  localparam logic [INTERVAL_W-1:0] ONE_SPACE_MAX_US  = 16'd1900;
  localparam logic [INTERVAL_W-1:0] ZERO_SPACE_MIN_US = 16'd400;
  localparam logic [INTERVAL_W-1:0] ZERO_SPACE_MAX_US = 16'd700;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_MARK_MIN  = 3'd0,
    REG_START_MARK_MAX  = 3'd1,
    REG_START_SPACE_MIN = 3'd2,
    REG_START_SPACE_MAX = 3'd3,
    REG_ONE_PERIOD_MIN  = 3'd4,
    REG_ONE_PERIOD_MAX  = 3'd5,
    REG_ZERO_PERIOD_MIN = 3'd6,
    REG_ZERO_PERIOD_MAX = 3'd7
  } reg_idx_t;

  localparam logic [INTERVAL_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd8000, 16'd10000, 16'd4000, 16'd5000, 16'd2000, 16'd2500, 16'd900, 16'd1350
  };

  typedef struct packed {
    logic [INTERVAL_W-1:0] mark_min;
    logic [INTERVAL_W-1:0] mark_max;
    logic [INTERVAL_W-1:0] space_min;
    logic [INTERVAL_W-1:0] space_max;
  } start_cfg_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] one_min;
    logic [INTERVAL_W-1:0] one_max;
    logic [INTERVAL_W-1:0] zero_min;
    logic [INTERVAL_W-1:0] zero_max;
  } period_cfg_t;

  // classified edge travelling from front to back
  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic                  clear;
    logic                  start_mark_ok;
    logic                  start_space_ok;
    logic                  symbol_ok;
  } item_t;

endpackage

// File: src/nec_ir_frame_receiver.sv
// nec_ir_frame_receiver: top level, configuration registers and the front/queue/back chain
// depends on nir_pkg, nir_front, nir_fifo, nir_back
//
//  channel   direction  handshake                content
//  s_*       in         s_tvalid / s_tready      one edge interval per transaction
//  m_*       out        m_tvalid / m_tready      decoder status after each edge
//  cfg_*     in         cfg_wen                  window register write, no read-back
//
// one transaction in and one out per cycle while m_tready is high; an input edge reaches its
// result through the two-entry queue and the result register in the back part
// rst clears decoder state and reloads the window registers with their defaults
// a stalled result holds the back part; the queue keeps taking input until full

module nec_ir_frame_receiver import nir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // interval_us[15:0], line_high[16], zero pad
  input  logic                  s_tuser,   // clear[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // frame_done[0], frame_error[1], command_first[9:2],
                                           // command_second[17:10], data_first[25:18],
                                           // data_second[33:26], edges_seen[40:34], zero pad
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [INTERVAL_W-1:0] cfg_wdata
);

  logic [INTERVAL_W-1:0] regs [NUM_REGS];
  start_cfg_t            start_cfg;
  period_cfg_t           period_cfg;
  logic                  push, full, pop, not_empty;
  item_t                 push_item, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_wen) begin
      regs[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    start_cfg.mark_min   = regs[REG_START_MARK_MIN];
    start_cfg.mark_max   = regs[REG_START_MARK_MAX];
    start_cfg.space_min  = regs[REG_START_SPACE_MIN];
    start_cfg.space_max  = regs[REG_START_SPACE_MAX];
    period_cfg.one_min   = regs[REG_ONE_PERIOD_MIN];
    period_cfg.one_max   = regs[REG_ONE_PERIOD_MAX];
    period_cfg.zero_min  = regs[REG_ZERO_PERIOD_MIN];
    period_cfg.zero_max  = regs[REG_ZERO_PERIOD_MAX];
  end

  nir_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .start_cfg (start_cfg),
    .fifo_full (full),
    .push      (push),
    .push_item (push_item)
  );

  nir_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  nir_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .period_cfg (period_cfg),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// File: src/nir_front.sv
// nir_front: accepts input transactions and classifies the interval against the windows
// depends on nir_pkg; feeds nir_fifo

module nir_front import nir_pkg::*; (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,
  input  logic                  s_tuser,
  input  start_cfg_t            start_cfg,
  input  logic                  fifo_full,
  output logic                  push,
  output item_t                 push_item
);

  logic [INTERVAL_W-1:0] t;
  logic                  line_high;

  assign t         = s_tdata[INTERVAL_W-1:0];
  assign line_high = s_tdata[INTERVAL_W];
  assign s_tready  = !fifo_full;
  assign push      = s_tvalid && !fifo_full;

  always_comb begin
    push_item.interval       = t;
    push_item.clear          = s_tuser;
    push_item.start_mark_ok  = line_high && (t >= start_cfg.mark_min)
                               && (t <= start_cfg.mark_max);
    push_item.start_space_ok = (t >= start_cfg.space_min) && (t <= start_cfg.space_max);
    push_item.symbol_ok      = ((t >= MARK_MIN_US) && (t <= MARK_MAX_US))
                               || ((t >= ONE_SPACE_MIN_US) && (t <= ONE_SPACE_MAX_US))
                               || ((t >= ZERO_SPACE_MIN_US) && (t <= ZERO_SPACE_MAX_US));
  end

endmodule

// File: src/nir_fifo.sv
// nir_fifo: two-entry queue of classified edges between front and back
// depends on nir_pkg

module nir_fifo import nir_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("queue written while full");
  no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

// File: src/nir_back.sv
// nir_back: frame decoder state, bit assembly and the registered result
// depends on nir_pkg; takes classified edges from nir_fifo

module nir_back import nir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  item_t       head,
  output logic        pop,
  input  period_cfg_t period_cfg,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata
);

  logic [EDGE_W-1:0]     edge_count, edge_count_next;
  logic [INTERVAL_W-1:0] prev_interval, prev_interval_next;
  logic                  err, err_next;
  logic [7:0]            frame_bytes [4];
  logic [7:0]            frame_bytes_next [4];

  logic [INTERVAL_W:0]   sum;
  logic [EDGE_W-1:0]     cnt_inc;
  logic [4:0]            bit_idx;
  logic                  one_hit, zero_hit;

  assign pop     = not_empty && (!m_tvalid || m_tready);
  assign sum     = {1'b0, head.interval} + {1'b0, prev_interval};
  assign cnt_inc = edge_count + 1'b1;
  assign bit_idx = cnt_inc[5:1] - 5'd2;
  assign one_hit = (sum >= {1'b0, period_cfg.one_min}) && (sum <= {1'b0, period_cfg.one_max});
  assign zero_hit = (sum >= {1'b0, period_cfg.zero_min})
                    && (sum <= {1'b0, period_cfg.zero_max});

  always_comb begin
    edge_count_next    = edge_count;
    prev_interval_next = prev_interval;
    err_next           = err;
    frame_bytes_next   = frame_bytes;
    if (head.clear) begin
      edge_count_next    = '0;
      prev_interval_next = '0;
      err_next           = 1'b0;
      for (int i = 0; i < 4; i++) frame_bytes_next[i] = '0;
    end else if (!err && edge_count < FRAME_EDGES) begin
      priority if (edge_count == '0) begin
        if (head.start_mark_ok) edge_count_next = 7'd1;
        else err_next = 1'b1;
      end else if (edge_count == 7'd1) begin
        if (head.start_space_ok) edge_count_next = 7'd2;
        else err_next = 1'b1;
        prev_interval_next = head.interval;
      end else begin
        prev_interval_next = head.interval;
        if (!head.symbol_ok) begin
          err_next = 1'b1;
        end else begin
          edge_count_next = cnt_inc;
          if (!cnt_inc[0] && cnt_inc < FRAME_EDGES) begin
            priority if (one_hit) frame_bytes_next[bit_idx[4:3]][bit_idx[2:0]] = 1'b1;
            else if (zero_hit) frame_bytes_next[bit_idx[4:3]][bit_idx[2:0]] = 1'b0;
            else err_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      prev_interval <= '0;
      err           <= 1'b0;
      for (int i = 0; i < 4; i++) frame_bytes[i] <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (pop) begin
        edge_count    <= edge_count_next;
        prev_interval <= prev_interval_next;
        err           <= err_next;
        frame_bytes   <= frame_bytes_next;
      end
      if (pop) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, edge_count, frame_bytes[3], frame_bytes[2], frame_bytes[1],
                    frame_bytes[0], err, (edge_count >= FRAME_EDGES)};

  count_bound: assert property (@(posedge clk) disable iff (rst) edge_count <= FRAME_EDGES)
    else $error("edge count past end of frame");
  error_freezes: assert property (@(posedge clk) disable iff (rst)
    (err && !(pop && head.clear)) |=> $stable(edge_count) && err)
    else $error("latched error did not hold the frame");
  done_holds: assert property (@(posedge clk) disable iff (rst)
    (edge_count == FRAME_EDGES && !(pop && head.clear)) |=> edge_count == FRAME_EDGES)
    else $error("finished frame changed without clear");

endmodule

// File: sim/nir_status_monitor.sv
`timescale 1ns / 100ps
// nir_status_monitor: follows the edge, status and window register channels of the nec frame
// receiver, keeps its own copy of the decoder state and checks every status transaction
// depends on nir_pkg

module nir_status_monitor import nir_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [23:0]           s_tdata,   // interval_us[15:0], line_high[16], zero pad
  input  logic                  s_tuser,   // clear[0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [47:0]           m_tdata,   // frame_done[0], frame_error[1], command_first[9:2],
                                           // command_second[17:10], data_first[25:18],
                                           // data_second[33:26], edges_seen[40:34], zero pad
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [INTERVAL_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [EDGE_W-1:0] edges_seen;
    logic [7:0]        data_second;
    logic [7:0]        data_first;
    logic [7:0]        command_second;
    logic [7:0]        command_first;
    logic              frame_error;
    logic              frame_done;
  } frame_status_t;

  logic [INTERVAL_W-1:0] win_reg [NUM_REGS];
  logic [EDGE_W-1:0]     edge_cnt;
  logic [INTERVAL_W-1:0] last_interval;
  logic                  err_flag;
  logic [7:0]            rx_bytes [4];
  frame_status_t         expected_status_q [$];

  function automatic logic fits(logic [16:0] v, logic [INTERVAL_W-1:0] lo,
                                logic [INTERVAL_W-1:0] hi);
    return (v >= {1'b0, lo}) && (v <= {1'b0, hi});
  endfunction

  task automatic clear_decoder();
    edge_cnt      = '0;
    last_interval = '0;
    err_flag      = 1'b0;
    for (int i = 0; i < 4; i++) rx_bytes[i] = 8'd0;
  endtask

  task automatic step_decoder(input logic [INTERVAL_W-1:0] iv, input logic line_hi,
                              input logic clr);
    logic [16:0] period;
    logic [16:0] iv_w;
    int          bit_no;
    iv_w = {1'b0, iv};
    if (clr) begin
      clear_decoder();
    end else if (!err_flag && edge_cnt < FRAME_EDGES) begin
      if (edge_cnt == 0) begin
        if (line_hi && fits(iv_w, win_reg[REG_START_MARK_MIN], win_reg[REG_START_MARK_MAX]))
          edge_cnt = 7'd1;
        else
          err_flag = 1'b1;
      end else if (edge_cnt == 1) begin
        if (fits(iv_w, win_reg[REG_START_SPACE_MIN], win_reg[REG_START_SPACE_MAX]))
          edge_cnt = 7'd2;
        else
          err_flag = 1'b1;
        last_interval = iv;
      end else begin
        if (!(fits(iv_w, MARK_MIN_US, MARK_MAX_US) ||
              fits(iv_w, ONE_SPACE_MIN_US, ONE_SPACE_MAX_US) ||
              fits(iv_w, ZERO_SPACE_MIN_US, ZERO_SPACE_MAX_US))) begin
          err_flag = 1'b1;
        end else begin
          edge_cnt = edge_cnt + 7'd1;
          if (!edge_cnt[0] && edge_cnt < FRAME_EDGES) begin
            bit_no = int'(edge_cnt >> 1) - 2;
            period = {1'b0, iv} + {1'b0, last_interval};
            if (fits(period, win_reg[REG_ONE_PERIOD_MIN], win_reg[REG_ONE_PERIOD_MAX]))
              rx_bytes[bit_no / 8][bit_no % 8] = 1'b1;
            else if (fits(period, win_reg[REG_ZERO_PERIOD_MIN], win_reg[REG_ZERO_PERIOD_MAX]))
              rx_bytes[bit_no / 8][bit_no % 8] = 1'b0;
            else
              err_flag = 1'b1;
          end
        end
        last_interval = iv;
      end
    end
  endtask

  function automatic frame_status_t current_status();
    frame_status_t st;
    st.frame_done     = (edge_cnt >= FRAME_EDGES);
    st.frame_error    = err_flag;
    st.command_first  = rx_bytes[0];
    st.command_second = rx_bytes[1];
    st.data_first     = rx_bytes[2];
    st.data_second    = rx_bytes[3];
    st.edges_seen     = edge_cnt;
    return st;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_status_t want;
    frame_status_t got;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) win_reg[i] = REG_RESET[i];
      clear_decoder();
      expected_status_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = frame_status_t'(m_tdata[40:0]);
        if (expected_status_q.size() == 0) begin
          $display("%0t ns: status transaction with none expected, expected nothing, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
          check_field("frame_error", 16'(want.frame_error), 16'(got.frame_error));
          check_field("command_first", 16'(want.command_first), 16'(got.command_first));
          check_field("command_second", 16'(want.command_second), 16'(got.command_second));
          check_field("data_first", 16'(want.data_first), 16'(got.data_first));
          check_field("data_second", 16'(want.data_second), 16'(got.data_second));
          check_field("edges_seen", 16'(want.edges_seen), 16'(got.edges_seen));
        end
      end
      if (cfg_wen) win_reg[cfg_index] = cfg_wdata;
      if (s_tvalid && s_tready) begin
        step_decoder(s_tdata[15:0], s_tdata[16], s_tuser);
        expected_status_q.push_back(current_status());
      end
    end
    pending = expected_status_q.size();
  end

endmodule

// File: sim/nec_ir_frame_receiver_tb.sv
`timescale 1ns / 100ps
// nec_ir_frame_receiver_tb: drives edge intervals and window register writes into the
// nec frame receiver and gives the verdict; checking is done in nir_status_monitor
// depends on nir_pkg, nir_status_monitor and the receiver rtl

module nec_ir_frame_receiver_tb;
  import nir_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // window settings per phase, register order as in reg_idx_t
  localparam logic [15:0] PHASE_WINDOWS [6][NUM_REGS] = '{
    '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd1000, 16'd65535, 16'd0, 16'd65535},
    '{16'd9000, 16'd9000, 16'd4500, 16'd4500, 16'd2000, 16'd2300, 16'd1000, 16'd1100},
    '{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd3000, 16'd2000, 16'd2000, 16'd1000},
    '{16'd8000, 16'd10000, 16'd4000, 16'd5000, 16'd65535, 16'd0, 16'd0, 16'd65535},
    '{16'd8000, 16'd10000, 16'd4000, 16'd5000, 16'd1800, 16'd2600, 16'd2000, 16'd1000},
    '{16'd8000, 16'd10000, 16'd4000, 16'd5000, 16'd2000, 16'd2500, 16'd900, 16'd1350}
  };
  localparam int PHASE_END [7] = '{300, 650, 900, 940, 1150, 1350, 1750};

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // interval_us[15:0], line_high[16], zero pad
  logic                  s_tuser;   // clear[0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [47:0]           m_tdata;   // frame_done[0], frame_error[1], command_first[9:2],
                                    // command_second[17:10], data_first[25:18],
                                    // data_second[33:26], edges_seen[40:34], zero pad
  logic                  cfg_wen;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [INTERVAL_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  int                    src_idle = 38;
  int                    dst_idle = 58;
  int                    items_sent = 0;
  int                    cycles = 0;
  logic [15:0]           cfg_now [NUM_REGS];

  nec_ir_frame_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nir_status_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_in(input int lo, input int hi);
    return (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(65535, 0);
  endfunction

  // called and returning at a falling edge
  task automatic send_item(input logic [15:0] iv, input logic line_hi, input logic clr);
    if (items_sent < 580) begin
      src_idle = 38;
      dst_idle = 58;
    end else if (items_sent < 1160) begin
      src_idle = 58;
      dst_idle = 38;
    end else begin
      src_idle = 0;
      dst_idle = 0;
    end
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, line_hi, iv};
    s_tuser  <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_now[idx] = val;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one frame, optionally broken at one edge and cut off shortly after it
  task automatic send_frame(input int corrupt_at, input int tail);
    logic [15:0] iv [67];
    int          m;
    int          lo;
    int          hi;
    int          sp_lo;
    int          sp_hi;
    int          last;
    iv[0] = 16'(pick_in(int'(cfg_now[REG_START_MARK_MIN]), int'(cfg_now[REG_START_MARK_MAX])));
    iv[1] = 16'(pick_in(int'(cfg_now[REG_START_SPACE_MIN]),
                        int'(cfg_now[REG_START_SPACE_MAX])));
    for (int b = 0; b < 32; b++) begin
      m = $urandom_range(int'(MARK_MAX_US), int'(MARK_MIN_US));
      if ($urandom_range(1)) begin
        lo    = int'(cfg_now[REG_ONE_PERIOD_MIN]) - m;
        hi    = int'(cfg_now[REG_ONE_PERIOD_MAX]) - m;
        sp_lo = int'(ONE_SPACE_MIN_US);
        sp_hi = int'(ONE_SPACE_MAX_US);
      end else begin
        lo    = int'(cfg_now[REG_ZERO_PERIOD_MIN]) - m;
        hi    = int'(cfg_now[REG_ZERO_PERIOD_MAX]) - m;
        sp_lo = int'(ZERO_SPACE_MIN_US);
        sp_hi = int'(ZERO_SPACE_MAX_US);
      end
      if (lo < sp_lo) lo = sp_lo;
      if (hi > sp_hi) hi = sp_hi;
      iv[2 + 2 * b] = 16'(m);
      iv[3 + 2 * b] = 16'((lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(sp_hi, sp_lo));
    end
    iv[66] = 16'($urandom_range(int'(MARK_MAX_US), int'(MARK_MIN_US)));
    if (corrupt_at >= 0) begin
      if ($urandom_range(1))
        iv[corrupt_at] = 16'($urandom_range(65535, 0));
      else
        iv[corrupt_at] = iv[corrupt_at] + 16'($urandom_range(400)) - 16'd200;
    end
    last = (corrupt_at >= 0 && corrupt_at + 3 < 67) ? corrupt_at + 3 : 66;
    send_item(16'($urandom_range(65535, 0)), 1'($urandom_range(1)), 1'b1);
    for (int k = 0; k <= last; k++)
      send_item(iv[k], (k == corrupt_at) ? 1'($urandom_range(1)) : ((k % 2) == 0), 1'b0);
    repeat (tail) send_item(16'($urandom_range(65535, 0)), 1'($urandom_range(1)), 1'b0);
  endtask

  task automatic send_noise();
    logic [15:0] v;
    if ($urandom_range(4) != 0)
      send_item(16'($urandom_range(65535, 0)), 1'($urandom_range(1)), 1'b1);
    repeat ($urandom_range(12, 2)) begin
      case ($urandom_range(3))
        0:       v = 16'($urandom_range(65535, 0));
        1:       v = 16'(pick_in(int'(cfg_now[REG_START_MARK_MIN]),
                                 int'(cfg_now[REG_START_MARK_MAX])));
        2:       v = 16'(pick_in(int'(cfg_now[REG_START_SPACE_MIN]),
                                 int'(cfg_now[REG_START_SPACE_MAX])));
        default: v = 16'($urandom_range(int'(ONE_SPACE_MAX_US), int'(MARK_MIN_US)));
      endcase
      send_item(v, 1'($urandom_range(1)), ($urandom_range(19) == 0));
    end
  endtask

  initial begin
    int roll;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < NUM_REGS; i++) cfg_now[i] = REG_RESET[i];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // window edges, bad start, rejected interval, bad period, ignored after error
    send_item(16'($urandom_range(65535, 0)), 1'b1, 1'b1);
    send_item(16'd0, 1'b1, 1'b0);
    send_item(16'd5000, 1'b0, 1'b0);
    send_item(16'd0, 1'b0, 1'b1);
    send_item(16'd65535, 1'b1, 1'b0);
    send_item(16'd65535, 1'b1, 1'b1);
    send_item(16'd8000, 1'b0, 1'b0);
    send_item(16'd1234, 1'b0, 1'b1);
    send_item(16'd8000, 1'b1, 1'b0);
    send_item(16'd3999, 1'b0, 1'b0);
    send_item(16'd0, 1'b1, 1'b1);
    send_item(16'd10000, 1'b1, 1'b0);
    send_item(16'd5000, 1'b0, 1'b0);
    send_item(16'd65535, 1'b1, 1'b0);
    send_item(16'd77, 1'b0, 1'b1);
    send_item(16'd8000, 1'b1, 1'b0);
    send_item(16'd4000, 1'b0, 1'b0);
    send_item(16'd400, 1'b1, 1'b0);
    send_item(16'd1900, 1'b0, 1'b0);
    send_item(16'd700, 1'b1, 1'b0);
    send_item(16'd700, 1'b0, 1'b0);
    send_item(16'd32768, 1'b1, 1'b1);
    send_item(16'd9000, 1'b1, 1'b0);
    send_item(16'd4500, 1'b0, 1'b0);
    send_item(16'd500, 1'b1, 1'b0);
    send_item(16'd500, 1'b0, 1'b0);

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        wait_idle();
        for (int r = 0; r < NUM_REGS; r++) write_reg(reg_idx_t'(r), PHASE_WINDOWS[p - 1][r]);
        cfg_wen <= 1'b0;
      end
      while (items_sent < PHASE_END[p]) begin
        roll = $urandom_range(99);
        if (roll < 60)
          send_frame(-1, ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
        else if (roll < 80)
          send_frame($urandom_range(66), 0);
        else
          send_noise();
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
